// ===== hw/rtl/mcws_pkg.sv =====
// Package for the multi-client watchdog supervisor.
// Holds the slot geometry, operation and status codes, the table entry and the FSM type.
// No dependencies.
package mcws_pkg;

  localparam int MAX_SLOTS = 8;
  localparam int CLIENT_LIMIT = 8;
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_FEED = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic REG_HW_FEED_ENABLE = 1'b0;

  typedef enum logic [1:0] {
    STAT_INIT = 2'd0,
    STAT_ONLINE = 2'd1,
    STAT_OFFLINE = 2'd2,
    STAT_RECOVERING = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] timeout;
    logic [31:0] last_seen;
    status_t status;
    logic critical;
    logic report;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_FEED_RD,
    ST_FEED_WR,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_NOP
  } state_t;

endpackage

// ===== hw/rtl/multi_client_watchdog_supervisor.sv =====
// Top level of the multi-client watchdog supervisor.
// Keeps the client slots in one synchronous table memory and serves one request at a time.
// Depends on mcws_pkg.
//
// Channel   Direction  Handshake                   Payload
// request   in         start && !busy              operation, client_index, now_ms,
//                                                  client_timeout, is_critical, reports_fault
// result    out        done (one cycle)            fault_mask, hw_feed, accepted, slot
// config    in/out     psel, penable, pwrite       paddr, pwdata, prdata
//
// After acceptance, a register request passes through ST_REG, a feed through ST_FEED_RD and
// then ST_FEED_WR (table read, then write back; no write back when the slot is not registered),
// a tick through ST_TICK_RD and then ST_TICK_CHK once for each registered client, since the
// single table read port visits one slot per cycle. Other operation codes pass through ST_NOP.
// busy is high from acceptance until done; a new request may be taken in the done cycle.
// rst is synchronous and clears the client count, the feed enable and the control state.
// The receiver cannot stall: each result is shown for exactly one cycle.
module multi_client_watchdog_supervisor (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [2:0]  client_index,
  input  logic [31:0] now_ms,
  input  logic [31:0] client_timeout,
  input  logic        is_critical,
  input  logic        reports_fault,
  output logic        done,
  output logic [7:0]  fault_mask,
  output logic        hw_feed,
  output logic        accepted,
  output logic [2:0]  slot,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mcws_pkg::state_t state, state_next;

  logic [2:0]  req_index;
  logic [31:0] req_now;
  logic [31:0] req_timeout;
  logic        req_critical;
  logic        req_report;

  logic [mcws_pkg::CNT_W-1:0]  count, count_next;
  logic [mcws_pkg::SLOT_W-1:0] scan, scan_next;
  logic [7:0]                  mask, mask_next;
  logic                        crit_ok, crit_ok_next;
  logic                        hw_feed_enable;

  mcws_pkg::entry_t mem [mcws_pkg::MAX_SLOTS];
  mcws_pkg::entry_t rdata;
  mcws_pkg::entry_t wdata;
  logic                        mem_we, mem_re;
  logic [mcws_pkg::SLOT_W-1:0] mem_waddr, mem_raddr;

  logic       done_next, hw_feed_next, accepted_next;
  logic [7:0] fault_mask_next;
  logic [2:0] slot_next;

  logic        take;
  logic        feed_valid;
  logic [31:0] age;
  logic        expired;
  mcws_pkg::status_t new_status;
  logic [mcws_pkg::CNT_W-1:0] scan_plus;
  logic        cfg_write;

  assign take = start && !busy;
  assign busy = (state != mcws_pkg::ST_IDLE);
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == mcws_pkg::REG_HW_FEED_ENABLE) ? {31'd0, hw_feed_enable} : 32'd0;

  assign feed_valid = (32'(req_index) < 32'(count));
  assign age = req_now - rdata.last_seen;
  assign expired = (age > rdata.timeout) && (rdata.status != mcws_pkg::STAT_OFFLINE);
  assign new_status = expired ? mcws_pkg::STAT_OFFLINE : rdata.status;
  assign scan_plus = mcws_pkg::CNT_W'(scan) + mcws_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mcws_pkg::ST_IDLE: begin
        if (take) begin
          unique case (operation)
            mcws_pkg::OP_REGISTER: state_next = mcws_pkg::ST_REG;
            mcws_pkg::OP_FEED:     state_next = mcws_pkg::ST_FEED_RD;
            mcws_pkg::OP_TICK:     state_next = mcws_pkg::ST_TICK_RD;
            default:               state_next = mcws_pkg::ST_NOP;
          endcase
        end
      end
      mcws_pkg::ST_REG:     state_next = mcws_pkg::ST_IDLE;
      mcws_pkg::ST_NOP:     state_next = mcws_pkg::ST_IDLE;
      mcws_pkg::ST_FEED_RD: state_next = feed_valid ? mcws_pkg::ST_FEED_WR : mcws_pkg::ST_IDLE;
      mcws_pkg::ST_FEED_WR: state_next = mcws_pkg::ST_IDLE;
      mcws_pkg::ST_TICK_RD: begin
        state_next = (count == '0) ? mcws_pkg::ST_IDLE : mcws_pkg::ST_TICK_CHK;
      end
      mcws_pkg::ST_TICK_CHK: begin
        if (scan_plus == count) begin
          state_next = mcws_pkg::ST_IDLE;
        end
      end
      default: state_next = mcws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    wdata = rdata;
    count_next = count;
    scan_next = scan;
    mask_next = mask;
    crit_ok_next = crit_ok;
    done_next = 1'b0;
    fault_mask_next = '0;
    hw_feed_next = 1'b0;
    accepted_next = 1'b0;
    slot_next = '0;
    unique case (state)
      mcws_pkg::ST_IDLE: begin
      end
      mcws_pkg::ST_REG: begin
        done_next = 1'b1;
        if (count < mcws_pkg::CNT_W'(mcws_pkg::MAX_SLOTS)) begin
          mem_we = 1'b1;
          mem_waddr = mcws_pkg::SLOT_W'(count);
          wdata.timeout = req_timeout;
          wdata.last_seen = '0;
          wdata.status = mcws_pkg::STAT_INIT;
          wdata.critical = req_critical;
          wdata.report = req_report;
          count_next = count + mcws_pkg::CNT_W'(1);
          accepted_next = 1'b1;
          slot_next = 3'(mcws_pkg::SLOT_W'(count));
        end
      end
      mcws_pkg::ST_NOP: begin
        done_next = 1'b1;
      end
      mcws_pkg::ST_FEED_RD: begin
        if (feed_valid) begin
          mem_re = 1'b1;
          mem_raddr = mcws_pkg::SLOT_W'(req_index);
        end else begin
          done_next = 1'b1;
        end
      end
      mcws_pkg::ST_FEED_WR: begin
        done_next = 1'b1;
        accepted_next = 1'b1;
        mem_we = 1'b1;
        mem_waddr = mcws_pkg::SLOT_W'(req_index);
        wdata.last_seen = req_now;
        unique case (rdata.status)
          mcws_pkg::STAT_INIT:       wdata.status = mcws_pkg::STAT_ONLINE;
          mcws_pkg::STAT_OFFLINE:    wdata.status = mcws_pkg::STAT_RECOVERING;
          mcws_pkg::STAT_RECOVERING: wdata.status = mcws_pkg::STAT_ONLINE;
          default:                   wdata.status = rdata.status;
        endcase
      end
      mcws_pkg::ST_TICK_RD: begin
        scan_next = '0;
        mask_next = '0;
        crit_ok_next = 1'b1;
        if (count == '0) begin
          done_next = 1'b1;
          hw_feed_next = hw_feed_enable;
        end else begin
          mem_re = 1'b1;
          mem_raddr = '0;
        end
      end
      mcws_pkg::ST_TICK_CHK: begin
        if (expired) begin
          mem_we = 1'b1;
          mem_waddr = scan;
          wdata.status = mcws_pkg::STAT_OFFLINE;
          if (rdata.report) begin
            mask_next = mask | (8'd1 << scan);
          end
        end
        if (rdata.critical && (new_status != mcws_pkg::STAT_ONLINE)) begin
          crit_ok_next = 1'b0;
        end
        if (scan_plus == count) begin
          done_next = 1'b1;
          fault_mask_next = mask_next;
          hw_feed_next = hw_feed_enable && crit_ok_next;
        end else begin
          mem_re = 1'b1;
          mem_raddr = mcws_pkg::SLOT_W'(scan_plus);
          scan_next = mcws_pkg::SLOT_W'(scan_plus);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcws_pkg::ST_IDLE;
      count <= '0;
      hw_feed_enable <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done <= done_next;
      if (cfg_write && (paddr[2] == mcws_pkg::REG_HW_FEED_ENABLE)) begin
        hw_feed_enable <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_index <= client_index;
      req_now <= now_ms;
      req_timeout <= client_timeout;
      req_critical <= is_critical;
      req_report <= reports_fault;
    end
    scan <= scan_next;
    mask <= mask_next;
    crit_ok <= crit_ok_next;
    fault_mask <= fault_mask_next;
    hw_feed <= hw_feed_next;
    accepted <= accepted_next;
    slot <= slot_next;
  end

endmodule

// ===== tb/multi_client_watchdog_supervisor_checker.sv =====
`timescale 1ns / 1ps
// Checker for the multi-client watchdog supervisor: tracks every accepted request and each
// configuration write to CFG_ADDR, keeps its own client table and compares each result with its forecast.
// Depends on mcws_pkg.
module multi_client_watchdog_supervisor_checker #(
  parameter logic [2:0] CFG_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation,
  input  logic [2:0]  client_index,
  input  logic [31:0] now_ms,
  input  logic [31:0] client_timeout,
  input  logic        is_critical,
  input  logic        reports_fault,
  input  logic        done,
  input  logic [7:0]  fault_mask,
  input  logic        hw_feed,
  input  logic        accepted,
  input  logic [2:0]  slot,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          results_pending
);

  typedef struct packed {
    logic [7:0] fault_mask;
    logic       hw_feed;
    logic       accepted;
    logic [2:0] slot;
  } outcome_t;

  int                client_count;
  logic [31:0]       limit_ms [mcws_pkg::MAX_SLOTS];
  logic [31:0]       seen_ms [mcws_pkg::MAX_SLOTS];
  mcws_pkg::status_t client_status [mcws_pkg::MAX_SLOTS];
  logic              critical [mcws_pkg::MAX_SLOTS];
  logic              reports [mcws_pkg::MAX_SLOTS];
  logic              feed_enable;
  outcome_t          forecast_q[$];

  initial begin
    mismatch_count = 0;
    results_pending = 0;
  end

  function automatic outcome_t supervise(input logic [1:0] op, input logic [2:0] idx,
                                         input logic [31:0] now, input logic [31:0] tmo,
                                         input logic crit, input logic rep);
    outcome_t res;
    logic [31:0] age;
    logic healthy;
    res = '0;
    case (op)
      mcws_pkg::OP_REGISTER: begin
        if (client_count < mcws_pkg::MAX_SLOTS) begin
          limit_ms[client_count] = tmo;
          seen_ms[client_count] = '0;
          client_status[client_count] = mcws_pkg::STAT_INIT;
          critical[client_count] = crit;
          reports[client_count] = rep;
          res.accepted = 1'b1;
          res.slot = 3'(client_count);
          client_count++;
        end
      end
      mcws_pkg::OP_FEED: begin
        if (int'(idx) < client_count && int'(idx) < mcws_pkg::MAX_SLOTS) begin
          seen_ms[idx] = now;
          case (client_status[idx])
            mcws_pkg::STAT_INIT: client_status[idx] = mcws_pkg::STAT_ONLINE;
            mcws_pkg::STAT_OFFLINE: client_status[idx] = mcws_pkg::STAT_RECOVERING;
            mcws_pkg::STAT_RECOVERING: client_status[idx] = mcws_pkg::STAT_ONLINE;
            default: ;
          endcase
          res.accepted = 1'b1;
        end
      end
      mcws_pkg::OP_TICK: begin
        for (int i = 0; i < mcws_pkg::MAX_SLOTS; i++) begin
          if (i < client_count) begin
            age = now - seen_ms[i];
            if (age > limit_ms[i] && client_status[i] != mcws_pkg::STAT_OFFLINE) begin
              if (reports[i] && i < 8) res.fault_mask[i] = 1'b1;
              client_status[i] = mcws_pkg::STAT_OFFLINE;
            end
          end
        end
        healthy = 1'b1;
        for (int i = 0; i < mcws_pkg::MAX_SLOTS; i++) begin
          if (i < client_count && critical[i] &&
              client_status[i] != mcws_pkg::STAT_ONLINE) healthy = 1'b0;
        end
        res.hw_feed = feed_enable && healthy;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      client_count = 0;
      feed_enable = 1'b0;
      forecast_q.delete();
      for (int i = 0; i < mcws_pkg::MAX_SLOTS; i++) begin
        limit_ms[i] = '0;
        seen_ms[i] = '0;
        client_status[i] = mcws_pkg::STAT_INIT;
        critical[i] = 1'b0;
        reports[i] = 1'b0;
      end
    end else begin
      if (done) begin
        if (forecast_q.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none actual %h %h %h %h",
                   $time, fault_mask, hw_feed, accepted, slot);
          mismatch_count++;
        end else begin
          want = forecast_q.pop_front();
          compare_field("fault_mask", want.fault_mask, fault_mask);
          compare_field("hw_feed", 8'(want.hw_feed), 8'(hw_feed));
          compare_field("accepted", 8'(want.accepted), 8'(accepted));
          compare_field("slot", 8'(want.slot), 8'(slot));
        end
      end
      if (psel && penable && pwrite && pready && paddr == CFG_ADDR) feed_enable = pwdata[0];
      if (start && !busy) begin
        forecast_q.push_back(supervise(operation, client_index, now_ms, client_timeout,
                                       is_critical, reports_fault));
      end
    end
    results_pending <= forecast_q.size();
  end

endmodule

// ===== tb/multi_client_watchdog_supervisor_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the multi-client watchdog supervisor: clock, reset, request and
// configuration stimulus, and the final verdict.
// Depends on mcws_pkg, multi_client_watchdog_supervisor and its checker module.
module multi_client_watchdog_supervisor_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] FEED_ENABLE_ADDR = 3'(4 * int'(mcws_pkg::REG_HW_FEED_ENABLE));
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_REQUESTS = 850;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  operation;
  logic [2:0]  client_index;
  logic [31:0] now_ms;
  logic [31:0] client_timeout;
  logic        is_critical;
  logic        reports_fault;
  logic        done;
  logic [7:0]  fault_mask;
  logic        hw_feed;
  logic        accepted;
  logic [2:0]  slot;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatch_count;
  int          results_pending;
  int          cycle_count = 0;
  logic [31:0] now_base;
  logic        steady;

  always #6 clk = ~clk;

  multi_client_watchdog_supervisor DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .client_index(client_index), .now_ms(now_ms), .client_timeout(client_timeout),
    .is_critical(is_critical), .reports_fault(reports_fault), .done(done),
    .fault_mask(fault_mask), .hw_feed(hw_feed), .accepted(accepted), .slot(slot),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  multi_client_watchdog_supervisor_checker #(.CFG_ADDR(FEED_ENABLE_ADDR)) watcher (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .client_index(client_index), .now_ms(now_ms), .client_timeout(client_timeout),
    .is_critical(is_critical), .reports_fault(reports_fault), .done(done),
    .fault_mask(fault_mask), .hw_feed(hw_feed), .accepted(accepted), .slot(slot),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .mismatch_count(mismatch_count), .results_pending(results_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_client_watchdog_supervisor verification failed");
      $finish;
    end
  end

  task automatic issue(input logic [1:0] op, input logic [2:0] idx, input logic [31:0] now,
                       input logic [31:0] tmo, input logic crit, input logic rep);
    operation <= op;
    client_index <= idx;
    now_ms <= now;
    client_timeout <= tmo;
    is_critical <= crit;
    reports_fault <= rep;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic rest();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (steady || r < 55) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic write_feed_enable(input logic en);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FEED_ENABLE_ADDR;
    pwdata <= {31'($urandom), en};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int r;
    logic [1:0] op;
    logic [31:0] now;
    logic [31:0] tmo;
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) op = mcws_pkg::OP_REGISTER;
      else if (r < 50) op = mcws_pkg::OP_FEED;
      else if (r < 95) op = mcws_pkg::OP_TICK;
      else op = OP_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 90) now_base = now_base + $urandom_range(0, 20);
      else if (r < 98) now_base = now_base + $urandom_range(20, 400);
      else now_base = now_base + $urandom;
      now = ($urandom_range(0, 9) == 0) ? $urandom : now_base;
      tmo = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300);
      issue(op, 3'($urandom_range(0, 7)), now, tmo, 1'($urandom), 1'($urandom));
      rest();
    end
    start <= 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    operation <= mcws_pkg::OP_REGISTER;
    client_index <= '0;
    now_ms <= '0;
    client_timeout <= '0;
    is_critical <= 1'b0;
    reports_fault <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    steady = 1'b0;
    now_base = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_feed_enable(1'b1);

    // Empty table, unregistered feeds, the unused code, then a table filled in stages.
    issue(mcws_pkg::OP_TICK, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0);                  rest();
    issue(mcws_pkg::OP_FEED, 3'd0, 32'd10, 32'd0, 1'b0, 1'b0);                 rest();
    issue(OP_UNUSED, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0);                          rest();
    issue(mcws_pkg::OP_REGISTER, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1);              rest();
    issue(mcws_pkg::OP_TICK, 3'd0, 32'd5, 32'd0, 1'b0, 1'b0);                  rest();
    issue(mcws_pkg::OP_REGISTER, 3'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);      rest();
    issue(mcws_pkg::OP_REGISTER, 3'd0, 32'd0, 32'd100, 1'b1, 1'b0);            rest();
    issue(mcws_pkg::OP_REGISTER, 3'd0, 32'd0, 32'h8000_0000, 1'b0, 1'b0);      rest();
    issue(mcws_pkg::OP_FEED, 3'd7, 32'd900, 32'd0, 1'b0, 1'b0);                rest();
    issue(mcws_pkg::OP_FEED, 3'd0, 32'd1000, 32'd0, 1'b0, 1'b0);               rest();
    issue(mcws_pkg::OP_FEED, 3'd2, 32'd1000, 32'd0, 1'b0, 1'b0);               rest();
    issue(mcws_pkg::OP_TICK, 3'd0, 32'd1000, 32'd0, 1'b0, 1'b0);               rest();
    issue(mcws_pkg::OP_FEED, 3'd0, 32'd1100, 32'd0, 1'b0, 1'b0);               rest();
    issue(mcws_pkg::OP_TICK, 3'd0, 32'd1100, 32'd0, 1'b0, 1'b0);               rest();
    issue(mcws_pkg::OP_TICK, 3'd0, 32'd1101, 32'd0, 1'b0, 1'b0);               rest();
    issue(mcws_pkg::OP_TICK, 3'd0, 32'd1200, 32'd0, 1'b0, 1'b0);               rest();
    issue(mcws_pkg::OP_REGISTER, 3'd0, 32'd0, 32'd50, 1'b0, 1'b1);             rest();
    issue(mcws_pkg::OP_FEED, 3'd4, 32'hFFFF_FFF0, 32'd0, 1'b0, 1'b0);          rest();
    issue(mcws_pkg::OP_TICK, 3'd0, 32'h0000_0010, 32'd0, 1'b0, 1'b0);          rest();
    issue(mcws_pkg::OP_TICK, 3'd0, 32'h0000_0060, 32'd0, 1'b0, 1'b0);          rest();
    issue(OP_UNUSED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);          rest();
    start <= 1'b0;
    drain();

    write_feed_enable(1'b0);
    now_base = 32'd2000;
    random_phase(RANDOM_REQUESTS);
    drain();

    write_feed_enable(1'b1);
    now_base = 32'hFFFF_FC00;
    random_phase(RANDOM_REQUESTS);
    drain();
    repeat (16) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("multi_client_watchdog_supervisor verification clean");
    end else begin
      $display("multi_client_watchdog_supervisor verification failed");
    end
    $finish;
  end

endmodule
